// ----- hdl/sau_pkg.sv -----
// ----------------------------------------------------------------------------
// sau_pkg
// Shared types, codes and microcode ROM for the stack arithmetic unit.
// ----------------------------------------------------------------------------
package sau_pkg;

  localparam int DataW  = 32;
  localparam int UpcW   = 4;
  localparam int ModeW  = 3;
  localparam int DepthW = 7;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_MUL  = 3'd4,
    MODE_MOD  = 3'd5
  } sau_mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } sau_status_e;

  typedef enum logic [2:0] {
    C_JUMP,
    C_HOLD_IN,
    C_DECODE,
    C_OPSEL,
    C_HOLD_DIV,
    C_HOLD_OUT
  } sau_cond_e;

  // microcode addresses
  localparam logic [UpcW-1:0] U_FETCH    = 4'd0;
  localparam logic [UpcW-1:0] U_DECODE   = 4'd1;
  localparam logic [UpcW-1:0] U_PUSH     = 4'd2;
  localparam logic [UpcW-1:0] U_FULL     = 4'd3;
  localparam logic [UpcW-1:0] U_SHORT    = 4'd4;
  localparam logic [UpcW-1:0] U_READ     = 4'd5;
  localparam logic [UpcW-1:0] U_OPSEL    = 4'd6;
  localparam logic [UpcW-1:0] U_ARITH    = 4'd7;
  localparam logic [UpcW-1:0] U_DIVZ     = 4'd8;
  localparam logic [UpcW-1:0] U_DIVSTART = 4'd9;
  localparam logic [UpcW-1:0] U_DIVSTEP  = 4'd10;
  localparam logic [UpcW-1:0] U_DIVDONE  = 4'd11;
  localparam logic [UpcW-1:0] U_EMIT     = 4'd12;

  typedef struct packed {
    sau_cond_e       cond;
    logic [UpcW-1:0] target;
    logic            in_take;
    logic            push;
    logic            rd_second;
    logic            arith;
    logic            div_start;
    logic            div_done;
    logic            clear;
    logic            st_set;
    sau_status_e     st_code;
    logic            emit;
  } sau_ctrl_t;

  typedef struct packed {
    logic             in_valid;
    logic [ModeW-1:0] mode;
    logic             full;
    logic             too_short;
    logic             top_zero;
    logic             div_busy;
    logic             out_busy;
  } sau_flags_t;

  function automatic sau_ctrl_t sau_rom(input logic [UpcW-1:0] upc);
    sau_ctrl_t cw;
    cw = '0;
    cw.cond    = C_JUMP;
    cw.target  = U_FETCH;
    cw.st_code = ST_OK;
    unique case (upc)
      U_FETCH: begin
        cw.cond    = C_HOLD_IN;
        cw.target  = U_DECODE;
        cw.in_take = 1'b1;
      end
      U_DECODE: cw.cond = C_DECODE;
      U_PUSH: begin
        cw.push   = 1'b1;
        cw.target = U_EMIT;
      end
      U_FULL: begin
        cw.st_set  = 1'b1;
        cw.st_code = ST_FULL;
        cw.target  = U_EMIT;
      end
      U_SHORT: begin
        cw.clear   = 1'b1;
        cw.st_set  = 1'b1;
        cw.st_code = ST_SHORT;
        cw.target  = U_EMIT;
      end
      U_READ: begin
        cw.rd_second = 1'b1;
        cw.target    = U_OPSEL;
      end
      U_OPSEL: cw.cond = C_OPSEL;
      U_ARITH: begin
        cw.arith  = 1'b1;
        cw.target = U_EMIT;
      end
      U_DIVZ: begin
        cw.clear   = 1'b1;
        cw.st_set  = 1'b1;
        cw.st_code = ST_DIVZERO;
        cw.target  = U_EMIT;
      end
      U_DIVSTART: begin
        cw.div_start = 1'b1;
        cw.target    = U_DIVSTEP;
      end
      U_DIVSTEP: begin
        cw.cond   = C_HOLD_DIV;
        cw.target = U_DIVDONE;
      end
      U_DIVDONE: begin
        cw.div_done = 1'b1;
        cw.target   = U_EMIT;
      end
      U_EMIT: begin
        cw.cond   = C_HOLD_OUT;
        cw.emit   = 1'b1;
        cw.target = U_FETCH;
      end
      default: cw.target = U_FETCH;
    endcase
    return cw;
  endfunction

  function automatic logic [UpcW-1:0] sau_decode(input logic [ModeW-1:0] mode,
                                                 input logic full,
                                                 input logic too_short);
    logic [UpcW-1:0] nxt;
    unique case (mode)
      MODE_PUSH: nxt = full ? U_FULL : U_PUSH;
      MODE_ADD, MODE_SUB, MODE_DIV, MODE_MUL, MODE_MOD:
        nxt = too_short ? U_SHORT : U_READ;
      default:   nxt = U_EMIT;
    endcase
    return nxt;
  endfunction

  function automatic logic [UpcW-1:0] sau_opsel(input logic [ModeW-1:0] mode,
                                                input logic top_zero);
    logic [UpcW-1:0] nxt;
    unique case (mode)
      MODE_DIV, MODE_MOD: nxt = top_zero ? U_DIVZ : U_DIVSTART;
      default:            nxt = U_ARITH;
    endcase
    return nxt;
  endfunction

endpackage

// ----- hdl/sau_sequencer.sv -----
// ----------------------------------------------------------------------------
// sau_sequencer
// Micro-program counter and control ROM with conditional jumps.
// ----------------------------------------------------------------------------
module sau_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sau_pkg::sau_flags_t flags_i,
  output sau_pkg::sau_ctrl_t  ctrl_o
);
  import sau_pkg::*;

  logic [UpcW-1:0] upc_q, upc_d;
  sau_ctrl_t       cw;

  assign cw     = sau_rom(upc_q);
  assign ctrl_o = cw;

  always_comb begin
    unique case (cw.cond)
      C_JUMP:     upc_d = cw.target;
      C_HOLD_IN:  upc_d = flags_i.in_valid ? cw.target : upc_q;
      C_DECODE:   upc_d = sau_decode(flags_i.mode, flags_i.full, flags_i.too_short);
      C_OPSEL:    upc_d = sau_opsel(flags_i.mode, flags_i.top_zero);
      C_HOLD_DIV: upc_d = flags_i.div_busy ? upc_q : cw.target;
      C_HOLD_OUT: upc_d = flags_i.out_busy ? upc_q : cw.target;
      default:    upc_d = U_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ----- hdl/sau_divider.sv -----
// ----------------------------------------------------------------------------
// sau_divider
// Signed truncating divider, one restoring quotient bit per cycle.
// ----------------------------------------------------------------------------
module sau_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [sau_pkg::DataW-1:0] dividend_i,
  input  logic signed [sau_pkg::DataW-1:0] divisor_i,
  output logic                            busy_o,
  output logic        [sau_pkg::DataW-1:0] quot_o,
  output logic        [sau_pkg::DataW-1:0] rem_o
);
  import sau_pkg::*;

  localparam int CntW = $clog2(DataW + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] dsr_q, dsr_d;
  logic             qneg_q, qneg_d;
  logic             rneg_q, rneg_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   shifted;

  assign busy_o  = (cnt_q != '0);
  assign shifted = {rem_q, quo_q[DataW-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    if (start_i) begin
      cnt_d  = CntW'(DataW);
      quo_d  = dividend_i[DataW-1] ? DataW'(-dividend_i) : dividend_i;
      dsr_d  = divisor_i[DataW-1] ? DataW'(-divisor_i) : divisor_i;
      rem_d  = '0;
      qneg_d = dividend_i[DataW-1] ^ divisor_i[DataW-1];
      rneg_d = dividend_i[DataW-1];
    end else if (busy_o) begin
      cnt_d = cnt_q - CntW'(1);
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

  assign quot_o = qneg_q ? (~quo_q + DataW'(1)) : quo_q;
  assign rem_o  = rneg_q ? (~rem_q + DataW'(1)) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

endmodule

// ----- hdl/sau_datapath.sv -----
// ----------------------------------------------------------------------------
// sau_datapath
// Stack memory, top-of-stack register, entry count, ALU and status.
// ----------------------------------------------------------------------------
module sau_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sau_pkg::sau_ctrl_t                  ctrl_i,
  input  logic                                in_accept_i,
  input  logic [sau_pkg::ModeW-1:0]           mode_i,
  input  logic signed [sau_pkg::DataW-1:0]    push_value_i,
  input  logic [sau_pkg::DataW-1:0]           quot_i,
  input  logic [sau_pkg::DataW-1:0]           rem_i,
  output logic [$clog2(STACK_DEPTH+1)-1:0]    count_o,
  output logic [sau_pkg::DataW-1:0]           top_o,
  output logic [sau_pkg::DataW-1:0]           second_o,
  output logic [sau_pkg::ModeW-1:0]           mode_o,
  output sau_pkg::sau_status_e                status_o,
  output logic                                full_o,
  output logic                                too_short_o
);
  import sau_pkg::*;

  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [DataW-1:0] mem [STACK_DEPTH];

  logic [CntW-1:0]  count_q, count_d;
  logic [DataW-1:0] top_q, top_d;
  logic [DataW-1:0] second_q;
  logic [DataW-1:0] value_q;
  logic [ModeW-1:0] mode_q;
  sau_status_e      status_q, status_d;
  logic [CntW-1:0]  cnt_m1, cnt_m2;
  logic [DataW-1:0] alu;

  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_q - CntW'(2);

  always_comb begin
    unique case (mode_q)
      MODE_ADD: alu = second_q + top_q;
      MODE_SUB: alu = second_q - top_q;
      default:  alu = DataW'(second_q * top_q);
    endcase
  end

  always_comb begin
    count_d  = count_q;
    top_d    = top_q;
    status_d = status_q;
    if (in_accept_i) status_d = ST_OK;
    if (ctrl_i.st_set) status_d = ctrl_i.st_code;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.push) begin
      count_d = count_q + CntW'(1);
      top_d   = value_q;
    end else if (ctrl_i.arith) begin
      count_d = cnt_m1;
      top_d   = alu;
    end else if (ctrl_i.div_done) begin
      count_d = cnt_m1;
      top_d   = (mode_q == MODE_DIV) ? quot_i : rem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (in_accept_i) begin
      mode_q  <= mode_i;
      value_q <= push_value_i;
    end
  end

  // entries below the top live in memory; the top stays in top_q
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && count_q != '0) begin
      mem[cnt_m1[AddrW-1:0]] <= top_q;
    end
    if (ctrl_i.rd_second) begin
      second_q <= mem[cnt_m2[AddrW-1:0]];
    end
  end

  assign count_o     = count_q;
  assign top_o       = top_q;
  assign second_o    = second_q;
  assign mode_o      = mode_q;
  assign status_o    = status_q;
  assign full_o      = (count_q == CntW'(STACK_DEPTH));
  assign too_short_o = (count_q < CntW'(2));

endmodule

// ----- hdl/stack_arithmetic_unit_core.sv -----
// ----------------------------------------------------------------------------
// stack_arithmetic_unit_core
// Stack machine arithmetic unit: push, add, sub, mul, div and mod.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry mode_i and push_value_i; one
// transaction per item. Output channel: out_valid_o / out_stall_i carry
// top_value_o, entry_depth_o and status_o; exactly one result transaction
// per input transaction, in order.
// A microcoded sequencer runs one item at a time. Push stores the value
// and full sets its status before emit; underflow clears the stack; add,
// sub and mul read the second entry and apply the ALU; div and mod wait on
// the one-bit-per-cycle divider, or clear the stack when the divisor is
// zero; unused modes go straight to emit. The input is taken again in the
// cycle after the result is loaded, so no new item enters before then.
// The result sits in an output register: a stalled receiver holds it while
// the next item is already being worked; a second result waits in the
// sequencer until the register frees up.
// Reset empties the stack and the output register; no clearing pass is run.
// ----------------------------------------------------------------------------
module stack_arithmetic_unit_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sau_pkg::ModeW-1:0]         mode_i,
  input  logic signed [sau_pkg::DataW-1:0]  push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [sau_pkg::DataW-1:0]  top_value_o,
  output logic [sau_pkg::DepthW-1:0]        entry_depth_o,
  output logic [1:0]                        status_o
);
  import sau_pkg::*;

  localparam int CntW = $clog2(STACK_DEPTH + 1);

  sau_ctrl_t        ctrl;
  sau_flags_t       flags;
  sau_status_e      status;
  logic [CntW-1:0]  count;
  logic [DataW-1:0] top, second, quot, rem;
  logic [ModeW-1:0] mode;
  logic             full, too_short, div_busy, in_accept, out_busy, load;

  logic             out_valid_q;
  logic [DataW-1:0] top_value_q;
  logic [DepthW-1:0] depth_q;
  logic [1:0]       status_q;

  assign in_stall_o = !ctrl.in_take;
  assign in_accept  = in_valid_i && ctrl.in_take;
  assign out_busy   = out_valid_q && out_stall_i;
  assign load       = ctrl.emit && !out_busy;

  assign flags.in_valid  = in_valid_i;
  assign flags.mode      = mode;
  assign flags.full      = full;
  assign flags.too_short = too_short;
  assign flags.top_zero  = (top == '0);
  assign flags.div_busy  = div_busy;
  assign flags.out_busy  = out_busy;

  sau_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  sau_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_accept_i  (in_accept),
    .mode_i       (mode_i),
    .push_value_i (push_value_i),
    .quot_i       (quot),
    .rem_i        (rem),
    .count_o      (count),
    .top_o        (top),
    .second_o     (second),
    .mode_o       (mode),
    .status_o     (status),
    .full_o       (full),
    .too_short_o  (too_short)
  );

  sau_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (second),
    .divisor_i  (top),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      top_value_q <= (count == '0) ? '0 : top;
      depth_q     <= DepthW'(count);
      status_q    <= status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign top_value_o   = top_value_q;
  assign entry_depth_o = depth_q;
  assign status_o      = status_q;

endmodule
